// ===== rtl/core/rlsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rlsf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_CHANNELS       = 4;
  localparam int unsigned DEF_COEF_FRAC_BITS = 16;

  // Field widths
  localparam int unsigned COEF_W  = 18;
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned SPD_W   = 25;
  localparam int unsigned OPB_W   = 25;                 // second multiplier operand
  localparam int unsigned PROD_W  = COEF_W + OPB_W;     // 43
  localparam int unsigned ACC_W   = PROD_W + 2;         // three products, no overflow
  localparam int unsigned ITEM_OUT_W = DIST_W + SPD_W;  // result bits per channel

  localparam logic signed [ACC_W-1:0] DIST_MAX = ACC_W'(64'sd16777215);
  localparam logic signed [ACC_W-1:0] SPD_MAX  = ACC_W'(64'sd16777215);
  localparam logic signed [ACC_W-1:0] SPD_MIN  = -ACC_W'(64'sd16777215);

  // Configuration register map
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DIST_GAIN_NEW = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIST_GAIN_OLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIST_FB_GAIN  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPD_GAIN_NEW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPD_GAIN_OLD  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPD_FB_GAIN   = 3'd5;

  localparam logic [COEF_W-1:0] RST_DIST_GAIN_NEW = COEF_W'(3121);
  localparam logic [COEF_W-1:0] RST_DIST_GAIN_OLD = COEF_W'(3121);
  localparam logic [COEF_W-1:0] RST_DIST_FB_GAIN  = COEF_W'(-59296);
  localparam logic [COEF_W-1:0] RST_SPD_GAIN_NEW  = COEF_W'(9362);
  localparam logic [COEF_W-1:0] RST_SPD_GAIN_OLD  = COEF_W'(9362);
  localparam logic [COEF_W-1:0] RST_SPD_FB_GAIN   = COEF_W'(-46811);

  // Lane sequencer steps
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_D_NEW   = 4'd0;   // multiply current sample
  localparam logic [STEP_W-1:0] STEP_D_OLD   = 4'd1;   // multiply previous sample
  localparam logic [STEP_W-1:0] STEP_D_FB    = 4'd2;   // multiply previous distance
  localparam logic [STEP_W-1:0] STEP_D_SUB   = 4'd3;   // subtract feedback product
  localparam logic [STEP_W-1:0] STEP_D_OUT   = 4'd4;   // round and clamp distance
  localparam logic [STEP_W-1:0] STEP_DIFF    = 4'd5;   // distance change
  localparam logic [STEP_W-1:0] STEP_S_NEW   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_S_OLD   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_S_FB    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_S_SUB   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_S_OUT   = 4'd10;  // round, clamp, commit history

  typedef struct packed {
    logic [COEF_W-1:0] dist_gain_new;
    logic [COEF_W-1:0] dist_gain_old;
    logic [COEF_W-1:0] dist_fb_gain;
    logic [COEF_W-1:0] spd_gain_new;
    logic [COEF_W-1:0] spd_gain_old;
    logic [COEF_W-1:0] spd_fb_gain;
  } coef_set_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rlsf_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlsf_lane
  import rlsf_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [RANGE_W-1:0]       range_i,
  input  coef_set_t                coef_i,
  output logic [DIST_W-1:0]        dist_o,
  output logic signed [SPD_W-1:0]  speed_o,
  output lane_stat_t               stat_o
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic                     busy_q;
  logic                     done_q;
  logic [STEP_W-1:0]        step_q;
  logic [RANGE_W-1:0]       x_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rnd;
  logic [DIST_W-1:0]        d_q;
  logic signed [SPD_W-1:0]  v_q;
  logic signed [COEF_W-1:0] op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic [DIST_W-1:0]        d_sat;
  logic signed [SPD_W-1:0]  s_sat;

  // History
  logic [RANGE_W-1:0]       last_range_q;
  logic [DIST_W-1:0]        last_dist_q;
  logic signed [SPD_W-1:0]  last_diff_q;
  logic signed [SPD_W-1:0]  last_spd_q;

  // Pick the operand pair for this step
  always_comb begin
    unique case (step_q)
      STEP_D_NEW: begin
        op_a = $signed(coef_i.dist_gain_new);
        op_b = $signed({1'b0, x_q, 8'b0});
      end
      STEP_D_OLD: begin
        op_a = $signed(coef_i.dist_gain_old);
        op_b = $signed({1'b0, last_range_q, 8'b0});
      end
      STEP_D_FB: begin
        op_a = $signed(coef_i.dist_fb_gain);
        op_b = $signed({1'b0, last_dist_q});
      end
      STEP_S_NEW: begin
        op_a = $signed(coef_i.spd_gain_new);
        op_b = v_q;
      end
      STEP_S_OLD: begin
        op_a = $signed(coef_i.spd_gain_old);
        op_b = last_diff_q;
      end
      STEP_S_FB: begin
        op_a = $signed(coef_i.spd_fb_gain);
        op_b = last_spd_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // Round half up, floor shift
  assign rnd = (acc_q + ROUND_HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    if (rnd < 0) begin
      d_sat = '0;
    end else if (rnd > DIST_MAX) begin
      d_sat = DIST_MAX[DIST_W-1:0];
    end else begin
      d_sat = rnd[DIST_W-1:0];
    end
  end

  always_comb begin
    if (rnd < SPD_MIN) begin
      s_sat = SPD_MIN[SPD_W-1:0];
    end else if (rnd > SPD_MAX) begin
      s_sat = SPD_MAX[SPD_W-1:0];
    end else begin
      s_sat = rnd[SPD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      done_q       <= 1'b0;
      step_q       <= STEP_D_NEW;
      last_range_q <= '0;
      last_dist_q  <= '0;
      last_diff_q  <= '0;
      last_spd_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_D_NEW;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_S_OUT) begin
          busy_q       <= 1'b0;
          done_q       <= 1'b1;
          last_range_q <= x_q;
          last_dist_q  <= d_q;
          last_diff_q  <= v_q;
          last_spd_q   <= s_sat;
        end
      end
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= range_i;
    end
    prod_q <= prod_d;
    if (busy_q) begin
      unique case (step_q)
        STEP_D_OLD, STEP_S_OLD: acc_q <= prod_ext;
        STEP_D_FB,  STEP_S_FB:  acc_q <= acc_q + prod_ext;
        STEP_D_SUB, STEP_S_SUB: acc_q <= acc_q - prod_ext;
        STEP_D_OUT:             d_q   <= d_sat;
        STEP_DIFF:              v_q   <= $signed({1'b0, d_q}) - $signed({1'b0, last_dist_q});
        default: ;
      endcase
    end
  end

  assign dist_o      = last_dist_q;
  assign speed_o     = last_spd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/rlsf_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rlsf_merge
  import rlsf_pkg::*;
#(
  parameter int unsigned CHANNELS = DEF_CHANNELS,
  parameter int unsigned OUT_W    = ((CHANNELS * ITEM_OUT_W + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [CHANNELS-1:0][DIST_W-1:0]    dist_i,
  input  logic [CHANNELS-1:0][SPD_W-1:0]     speed_i,
  output logic                               slot_free_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_W-1:0]                   m_axis_tdata
);

  logic             valid_q;
  logic [OUT_W-1:0] data_q;

  assign slot_free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Pack all distances first, then all speeds; channel 0 lowest
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= OUT_W'({speed_i, dist_i});
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/range_lowpass_and_speed_filter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Range smoother: every input beat carries one raw 16-bit range per channel;
// each channel runs a first-order low-pass on distance (unsigned Q16.8 out)
// and a second first-order low-pass on the change of that distance (signed
// Q17.8 out), both saturated. Each channel has its own lane with a single
// 18x25 multiplier that walks an eleven-step schedule. An item holds the
// block from one accepted beat to the next: the lanes walk their steps, the
// done flags load the output register, and the block returns to idle, where
// the next beat is taken. A new beat is taken while the previous result
// still waits on the master side; if the lanes finish before that result
// is taken, they hold until the output frees up.
// Coefficients are signed Q1.16 (COEF_FRAC_BITS fraction bits); the user
// must write them through the cfg port only while the block is idle, which
// the block itself does not enforce. All filter history clears at reset.
module range_lowpass_and_speed_filter_top
  import rlsf_pkg::*;
#(
  parameter int unsigned CHANNELS       = DEF_CHANNELS,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [REG_IDX_W-1:0]              cfg_addr_i,
  input  logic [COEF_W-1:0]                 cfg_wdata_i,
  // Input stream; tdata: range_0, range_1, ... (16 bits each)
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((CHANNELS*RANGE_W+7)/8)*8-1:0] s_axis_tdata,
  // Output stream; tdata: smooth_dist_0.. (24 bits each), then
  // smooth_speed_0.. (25 bits each), zero padded to whole bytes
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((CHANNELS*ITEM_OUT_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OUT_W = ((CHANNELS * ITEM_OUT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e    state_q, state_d;
  coef_set_t coef_q;

  logic                            s_fire;
  logic                            merge_load;
  logic                            slot_free;
  logic [CHANNELS-1:0]             lane_busy;
  logic [CHANNELS-1:0]             lane_done;
  logic [CHANNELS-1:0][DIST_W-1:0] lane_dist;
  logic [CHANNELS-1:0][SPD_W-1:0]  lane_speed;
  lane_stat_t                      lane_stat [CHANNELS];

  // Coefficient registers; writes past the last index drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.dist_gain_new <= RST_DIST_GAIN_NEW;
      coef_q.dist_gain_old <= RST_DIST_GAIN_OLD;
      coef_q.dist_fb_gain  <= RST_DIST_FB_GAIN;
      coef_q.spd_gain_new  <= RST_SPD_GAIN_NEW;
      coef_q.spd_gain_old  <= RST_SPD_GAIN_OLD;
      coef_q.spd_fb_gain   <= RST_SPD_FB_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DIST_GAIN_NEW: coef_q.dist_gain_new <= cfg_wdata_i;
        REG_DIST_GAIN_OLD: coef_q.dist_gain_old <= cfg_wdata_i;
        REG_DIST_FB_GAIN:  coef_q.dist_fb_gain  <= cfg_wdata_i;
        REG_SPD_GAIN_NEW:  coef_q.spd_gain_new  <= cfg_wdata_i;
        REG_SPD_GAIN_OLD:  coef_q.spd_gain_old  <= cfg_wdata_i;
        REG_SPD_FB_GAIN:   coef_q.spd_fb_gain   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Hand results to the output register once all lanes are done and the
  // slot is free; otherwise hold them in the lanes
  always_comb begin
    state_d    = state_q;
    merge_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (&lane_done) begin
          if (slot_free) begin
            merge_load = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          merge_load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One lane per channel
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    rlsf_lane #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (s_fire),
      .range_i (s_axis_tdata[c*RANGE_W +: RANGE_W]),
      .coef_i  (coef_q),
      .dist_o  (lane_dist[c]),
      .speed_o (lane_speed[c]),
      .stat_o  (lane_stat[c])
    );
    assign lane_busy[c] = lane_stat[c].busy;
    assign lane_done[c] = lane_stat[c].done;
  end

  rlsf_merge #(
    .CHANNELS (CHANNELS),
    .OUT_W    (OUT_W)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (merge_load),
    .dist_i        (lane_dist),
    .speed_i       (lane_speed),
    .slot_free_o   (slot_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_busy_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lane_busy) |-> (state_q == ST_RUN))
    else $error("lane busy outside run state");

  a_accept_starts_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> ((state_q == ST_RUN) && (&lane_busy)))
    else $error("accepted beat did not start all lanes");

  a_done_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lane_done) |-> (state_q == ST_RUN))
    else $error("lane finished outside run state");

  a_hold_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> m_axis_tvalid)
    else $error("holding results while output slot is empty");

  a_load_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_load |=> m_axis_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
